// ===== rtl/spq_pkg.sv =====
// shared types and codes for the stable priority queue
package spq_pkg;

  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PRIO_W = 2;
  localparam int unsigned OCC_W  = 5;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 2'd3;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_POP    = 2'd1,
    FN_PEEK   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADPRIO = 2'd3
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [PRIO_W-1:0] prio;
  } ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// one slot of the sorted chain: keeps, takes the new entry or shifts from a neighbor
module spq_cell #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                       clk,
  input  spq_pkg::ctrl_t             ctrl,
  input  logic                       occupied,
  input  logic                       left_ge,
  input  logic [TAG_BITS-1:0]        new_tag,
  input  logic [TAG_BITS-1:0]        left_tag,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [TAG_BITS-1:0]        right_tag,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                       ge,
  output logic [TAG_BITS-1:0]        tag,
  output logic [spq_pkg::PRIO_W-1:0] prio
);

  logic [TAG_BITS-1:0]        tag_r, tag_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_r, prio_nxt;

  assign ge   = occupied && (prio_r >= ctrl.prio);
  assign tag  = tag_r;
  assign prio = prio_r;

  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctrl.ins) begin
      if (!ge) begin
        if (left_ge) begin
          tag_nxt  = new_tag;
          prio_nxt = ctrl.prio;
        end else begin
          tag_nxt  = left_tag;
          prio_nxt = left_prio;
        end
      end
    end else if (ctrl.pop) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// stable priority queue top level: request handling, fill count and result register
// usage:
//   input channel in_valid/in_stall carries in_func, in_tag, in_prio; func insert
//   places the entry after all stored entries of greater or equal priority, pop
//   removes the head, peek reports it. every request gives exactly one result on
//   out_valid/out_stall with out_status, out_entry_tag, out_entry_prio and
//   out_occupancy (count after the request).
//   the result is registered, so out_valid rises in the cycle after acceptance;
//   one request per cycle is taken while the result side keeps up, because a row
//   of DEPTH slot cells compares against the new priority and shifts in parallel.
//   in_stall is high only while a result is held and out_stall is high, so the
//   held result never changes and no request is lost.
//   reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; slot contents are not cleared and are never read before written.
module stable_priority_queue #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [spq_pkg::TAG_W-1:0]   in_tag,
  input  logic [spq_pkg::PRIO_W-1:0]  in_prio,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [spq_pkg::TAG_W-1:0]   out_entry_tag,
  output logic [spq_pkg::PRIO_W-1:0]  out_entry_prio,
  output logic [spq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic [spq_pkg::TAG_W-1:0]  etag_r, etag_nxt;
  logic [spq_pkg::PRIO_W-1:0] eprio_r, eprio_nxt;

  logic in_acc;
  logic empty, full, bad_prio;
  spq_pkg::func_t func;
  spq_pkg::ctrl_t ctrl;

  logic [TAG_BITS-1:0]        new_tag;
  logic [TAG_BITS+spq_pkg::TAG_W-1:0] new_tag_ext;
  logic [TAG_BITS+spq_pkg::TAG_W-1:0] head_tag_ext;
  logic [CNT_W+spq_pkg::OCC_W-1:0]    occ_ext;

  logic                       ge   [DEPTH];
  logic [TAG_BITS-1:0]        tags [DEPTH];
  logic [spq_pkg::PRIO_W-1:0] prios[DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign func     = spq_pkg::func_t'(in_func);

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign bad_prio = (in_prio < spq_pkg::PRIO_MIN) || (in_prio > spq_pkg::PRIO_MAX);

  assign new_tag_ext  = {{TAG_BITS{1'b0}}, in_tag};
  assign new_tag      = new_tag_ext[TAG_BITS-1:0];
  assign head_tag_ext = {{spq_pkg::TAG_W{1'b0}}, tags[0]};

  always_comb begin
    ctrl       = '0;
    ctrl.prio  = in_prio;
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    etag_nxt   = '0;
    eprio_nxt  = '0;
    unique case (func)
      spq_pkg::FN_INSERT: begin
        priority if (bad_prio) begin
          status_nxt = spq_pkg::ST_BADPRIO;
        end else if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          ctrl.ins  = in_acc;
          count_nxt = in_acc ? count_r + 1'b1 : count_r;
        end
      end
      spq_pkg::FN_POP, spq_pkg::FN_PEEK: begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          etag_nxt  = head_tag_ext[spq_pkg::TAG_W-1:0];
          eprio_nxt = prios[0];
          if (func == spq_pkg::FN_POP) begin
            ctrl.pop  = in_acc;
            count_nxt = in_acc ? count_r - 1'b1 : count_r;
          end
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       occ;
    logic                       lge;
    logic [TAG_BITS-1:0]        ltag, rtag;
    logic [spq_pkg::PRIO_W-1:0] lprio, rprio;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign lge   = 1'b1;
      assign ltag  = new_tag;
      assign lprio = in_prio;
    end else begin : g_mid
      assign lge   = ge[i-1];
      assign ltag  = tags[i-1];
      assign lprio = prios[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rtag  = '0;
      assign rprio = '0;
    end else begin : g_body
      assign rtag  = tags[i+1];
      assign rprio = prios[i+1];
    end

    spq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .left_ge    (lge),
      .new_tag    (new_tag),
      .left_tag   (ltag),
      .left_prio  (lprio),
      .right_tag  (rtag),
      .right_prio (rprio),
      .ge         (ge[i]),
      .tag        (tags[i]),
      .prio       (prios[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      etag_r   <= etag_nxt;
      eprio_r  <= eprio_nxt;
    end
  end

  logic [CNT_W-1:0] occ_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      occ_r <= count_nxt;
    end
  end

  assign occ_ext        = {{spq_pkg::OCC_W{1'b0}}, occ_r};
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_entry_tag  = etag_r;
  assign out_entry_prio = eprio_r;
  assign out_occupancy  = occ_ext[spq_pkg::OCC_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("request taken while result held");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == spq_pkg::FN_POP && !empty) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not shrink queue");

  a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == spq_pkg::FN_INSERT && !bad_prio && !full)
      |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow queue");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request gave no result");

endmodule
